/* rtl/core/cat_pkg.sv */
// Shared types and constants for the compare/alarm timer.
package cat_pkg;

    localparam int NUM_ALARMS  = 3;
    localparam int SEL_W       = 2;
    localparam int DELAY_W     = 16;
    localparam int TAG_W       = 32;
    localparam int CHAN_W      = 2;
    localparam int HP_W        = 16;
    localparam int MAX_FIRE    = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [HP_W-1:0] HALF_PERIOD_RESET = 16'd1000;

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_SET    = 2'd1;
    localparam logic [1:0] MODE_CANCEL = 2'd2;
    localparam logic [1:0] MODE_START  = 2'd3;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_SET,
        OP_CANCEL,
        OP_START,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic [SEL_W-1:0]        sel;
        logic [DELAY_W-1:0]      delay;
        logic signed [TAG_W-1:0] tag;
    } t_cmd;

    typedef struct packed {
        logic busy;   // firings still waiting to go out
        logic pop;    // command taken from the queue this cycle
    } t_back_status;

endpackage

/* rtl/core/compare_alarm_timer.sv */
// Path: queue at acceptance, then the firing mask at pop, then the result register.
// Further firings of the same tick follow one per cycle while the output is taken.
// Throughput: one request per cycle while the queue is not full; a tick with firings
// holds the back end until the single result register has sent them one at a time.
// Reset (sync, active low): counter, targets and flags cleared, queue empty,
// half period back to 1000; alarm tags keep their contents until a set writes them.
module compare_alarm_timer #(
    parameter int COUNTER_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cat_pkg::HP_W-1:0]         i_cfg_half_period,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_mode,
    input  logic [cat_pkg::SEL_W-1:0]        i_alarm_select,
    input  logic [cat_pkg::DELAY_W-1:0]      i_delay_ticks,
    input  logic signed [cat_pkg::TAG_W-1:0] i_tag,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [cat_pkg::CHAN_W-1:0]       o_fired_channel,
    output logic signed [cat_pkg::TAG_W-1:0] o_fired_tag,
    output logic                             o_last
);
    import cat_pkg::*;

    logic [HP_W-1:0] r_half_period;
    logic            q_full;
    logic            push;
    t_cmd            front_cmd;
    logic            q_valid;
    t_cmd            q_cmd;
    t_back_status    back_st;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RESET;
        end else if (i_cfg_valid) begin
            r_half_period <= i_cfg_half_period;
        end
    end

    cat_front u_front (
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_alarm_select (i_alarm_select),
        .i_delay_ticks  (i_delay_ticks),
        .i_tag          (i_tag),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_cmd          (front_cmd)
    );

    cat_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (back_st.pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    cat_back #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_half_period   (r_half_period),
        .i_q_valid       (q_valid),
        .i_cmd           (q_cmd),
        .o_status        (back_st),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_fired_channel (o_fired_channel),
        .o_fired_tag     (o_fired_tag),
        .o_last          (o_last)
    );

    // no new command is started while firings of the previous tick remain
    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_st.pop |-> !back_st.busy)
        else $error("command popped while firings outstanding");

    // a non-final firing on the output implies more firings are queued behind it
    a_more_after_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> back_st.busy)
        else $error("firing without last flag but none left");

    // a full queue stays full, and the front stalled, until the back end pops from it
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_full && !back_st.pop) |=> q_full)
        else $error("queue emptied without a pop");

endmodule

/* rtl/core/cat_front.sv */
// Front end: accepts requests and classifies them into queue commands.
module cat_front (
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_mode,
    input  logic [cat_pkg::SEL_W-1:0]    i_alarm_select,
    input  logic [cat_pkg::DELAY_W-1:0]  i_delay_ticks,
    input  logic signed [cat_pkg::TAG_W-1:0] i_tag,
    input  logic                         i_q_full,
    output logic                         o_push,
    output cat_pkg::t_cmd                o_cmd
);
    import cat_pkg::*;

    logic sel_ok;
    t_op  op;

    assign sel_ok = 32'(i_alarm_select) < NUM_ALARMS;

    always_comb begin
        case (i_mode)
            MODE_TICK:   op = OP_TICK;
            MODE_SET:    op = sel_ok ? OP_SET : OP_NOP;
            MODE_CANCEL: op = sel_ok ? OP_CANCEL : OP_NOP;
            MODE_START:  op = OP_START;
            default:     op = OP_NOP;
        endcase
    end

    assign o_in_ready  = !i_q_full;
    assign o_push      = i_in_valid && !i_q_full;
    assign o_cmd.op    = op;
    assign o_cmd.sel   = i_alarm_select;
    assign o_cmd.delay = i_delay_ticks;
    assign o_cmd.tag   = i_tag;

endmodule

/* rtl/core/cat_queue.sv */
// Short command queue between front and back end.
module cat_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cat_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output cat_pkg::t_cmd o_cmd
);
    import cat_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* rtl/core/cat_back.sv */
// Back end: counter, compare channels, firing selection and result register.
module cat_back #(
    parameter int COUNTER_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [cat_pkg::HP_W-1:0]      i_half_period,
    input  logic                          i_q_valid,
    input  cat_pkg::t_cmd                 i_cmd,
    output cat_pkg::t_back_status         o_status,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [cat_pkg::CHAN_W-1:0]    o_fired_channel,
    output logic signed [cat_pkg::TAG_W-1:0] o_fired_tag,
    output logic                          o_last
);
    import cat_pkg::*;

    localparam int CH   = NUM_ALARMS + 1;
    localparam int PER  = NUM_ALARMS;
    localparam int CH_W = $clog2(CH);
    localparam int FC_W = $clog2(MAX_FIRE + 1);

    logic [COUNTER_BITS-1:0] r_count, n_count;
    logic [COUNTER_BITS-1:0] r_target [CH];
    logic [COUNTER_BITS-1:0] n_target [CH];
    logic [CH-1:0]           r_enabled, n_enabled;
    logic [CH-1:0]           r_pending, n_pending;
    logic [CH-1:0]           r_mask, n_mask;       // firings left to send
    logic signed [TAG_W-1:0] r_tag [NUM_ALARMS];

    logic                    r_out_valid, n_out_valid;
    logic [CHAN_W-1:0]       r_out_chan, n_out_chan;
    logic signed [TAG_W-1:0] r_out_tag, n_out_tag;
    logic                    r_out_last, n_out_last;

    logic                    pop;
    logic                    load;
    logic [COUNTER_BITS-1:0] cnt_inc;
    logic [COUNTER_BITS-1:0] delay_ext;
    logic [COUNTER_BITS-1:0] hp_ext;
    logic [CH-1:0]           pend;
    logic [CH-1:0]           fire;
    logic [FC_W-1:0]         fire_n;
    logic [CH_W-1:0]         pick;
    logic signed [TAG_W-1:0] pick_tag;

    assign pop       = i_q_valid && (r_mask == '0);
    assign load      = (r_mask != '0) && (!r_out_valid || i_out_ready);
    assign cnt_inc   = r_count + 1'b1;
    assign delay_ext = COUNTER_BITS'(i_cmd.delay);
    assign hp_ext    = COUNTER_BITS'(i_half_period);

    // priority: periodic first, then lowest alarm
    always_comb begin
        pick     = CH_W'(PER);
        pick_tag = '0;
        if (!r_mask[PER]) begin
            for (int i = NUM_ALARMS - 1; i >= 0; i--) begin
                if (r_mask[i]) begin
                    pick     = CH_W'(i);
                    pick_tag = r_tag[i];
                end
            end
        end
    end

    always_comb begin
        n_count     = r_count;
        n_target    = r_target;
        n_enabled   = r_enabled;
        n_pending   = r_pending;
        n_mask      = r_mask;
        n_out_valid = r_out_valid;
        n_out_chan  = r_out_chan;
        n_out_tag   = r_out_tag;
        n_out_last  = r_out_last;
        pend        = r_pending;
        fire        = '0;
        fire_n      = '0;

        if (pop) begin
            case (i_cmd.op)
                OP_SET: begin
                    for (int i = 0; i < NUM_ALARMS; i++) begin
                        if (32'(i_cmd.sel) == i) begin
                            n_target[i]  = r_count + delay_ext;
                            n_pending[i] = 1'b0;
                            n_enabled[i] = 1'b1;
                        end
                    end
                end
                OP_CANCEL: begin
                    for (int i = 0; i < NUM_ALARMS; i++) begin
                        if (32'(i_cmd.sel) == i) begin
                            n_pending[i] = 1'b0;
                            n_enabled[i] = 1'b0;
                        end
                    end
                end
                OP_START: begin
                    n_count        = '0;
                    n_pending      = '0;
                    n_enabled      = '0;
                    n_target[PER]  = hp_ext;
                    n_enabled[PER] = 1'b1;
                end
                OP_TICK: begin
                    n_count = cnt_inc;
                    // target matches latch as pending even on disabled channels
                    for (int i = 0; i < CH; i++) begin
                        if (r_target[i] == cnt_inc) begin
                            pend[i] = 1'b1;
                        end
                    end
                    if (pend[PER] && r_enabled[PER]) begin
                        fire[PER]     = 1'b1;
                        fire_n        = FC_W'(1);
                        n_target[PER] = r_target[PER] + hp_ext;
                    end
                    for (int i = 0; i < NUM_ALARMS; i++) begin
                        if (pend[i] && r_enabled[i] && (fire_n < FC_W'(MAX_FIRE))) begin
                            fire[i]      = 1'b1;
                            n_enabled[i] = 1'b0;
                            fire_n       = fire_n + 1'b1;
                        end
                    end
                    n_pending = pend & ~fire;
                    n_mask    = fire;
                end
                default: begin
                end
            endcase
        end

        if (load) begin
            n_mask[pick] = 1'b0;
            n_out_valid  = 1'b1;
            n_out_chan   = CHAN_W'(pick);
            n_out_tag    = pick_tag;
            n_out_last   = n_mask == '0;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_enabled   <= '0;
            r_pending   <= '0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CH; i++) begin
                r_target[i] <= '0;
            end
        end else begin
            r_count     <= n_count;
            r_target    <= n_target;
            r_enabled   <= n_enabled;
            r_pending   <= n_pending;
            r_mask      <= n_mask;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_chan <= n_out_chan;
        r_out_tag  <= n_out_tag;
        r_out_last <= n_out_last;
        for (int i = 0; i < NUM_ALARMS; i++) begin
            if (pop && (i_cmd.op == OP_SET) && (32'(i_cmd.sel) == i)) begin
                r_tag[i] <= i_cmd.tag;
            end
        end
    end

    assign o_status.busy  = r_mask != '0;
    assign o_status.pop   = pop;
    assign o_out_valid     = r_out_valid;
    assign o_fired_channel = r_out_chan;
    assign o_fired_tag     = r_out_tag;
    assign o_last          = r_out_last;

endmodule

/* test/testbench.sv */
// Self-checking testbench for the compare/alarm timer, with its own model of the timer.
`timescale 1ns / 100ps

module testbench;
    import cat_pkg::*;

    localparam int PERIODIC_CHAN  = NUM_ALARMS;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [CHAN_W-1:0]        chan;
        logic signed [TAG_W-1:0]  tag;
        logic                     last;
    } t_fire_rec;

    logic                     i_clk;
    logic                     i_rst_n           = 1'b0;
    logic                     i_cfg_valid       = 1'b0;
    logic                     o_cfg_ready;
    logic [HP_W-1:0]          i_cfg_half_period = '0;
    logic                     i_in_valid        = 1'b0;
    logic                     o_in_ready;
    logic [1:0]               i_mode            = MODE_TICK;
    logic [SEL_W-1:0]         i_alarm_select    = '0;
    logic [DELAY_W-1:0]       i_delay_ticks     = '0;
    logic signed [TAG_W-1:0]  i_tag             = '0;
    logic                     o_out_valid;
    logic                     i_out_ready       = 1'b0;
    logic [CHAN_W-1:0]        o_fired_channel;
    logic signed [TAG_W-1:0]  o_fired_tag;
    logic                     o_last;

    // timer model state
    logic [HP_W-1:0]          half_period_m;
    logic [15:0]              count_m;
    logic [15:0]              target_m  [NUM_ALARMS+1];
    logic                     enabled_m [NUM_ALARMS+1];
    logic                     pending_m [NUM_ALARMS+1];
    logic signed [TAG_W-1:0]  alarm_tag_m [NUM_ALARMS];

    t_fire_rec expected_firings [$];
    int        mismatch_count = 0;
    int        send_idle_pct  = 0;
    int        stall_pct      = 0;
    int        idle_cycles    = 0;

    compare_alarm_timer u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_half_period (i_cfg_half_period),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_mode            (i_mode),
        .i_alarm_select    (i_alarm_select),
        .i_delay_ticks     (i_delay_ticks),
        .i_tag             (i_tag),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_fired_channel   (o_fired_channel),
        .o_fired_tag       (o_fired_tag),
        .o_last            (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // ends the run when nothing moves on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: watchdog timeout, %0d firings outstanding", $time,
                     expected_firings.size());
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin : check_firings
        t_fire_rec want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_firings.size() == 0) begin
                $display("%0t: unexpected firing: expected none, actual chan %0d tag %0d last %0b",
                         $time, o_fired_channel, o_fired_tag, o_last);
                mismatch_count++;
            end else begin
                want = expected_firings.pop_front();
                if (o_fired_channel !== want.chan) begin
                    $display("%0t: fired_channel expected %0d actual %0d",
                             $time, want.chan, o_fired_channel);
                    mismatch_count++;
                end
                if (o_fired_tag !== want.tag) begin
                    $display("%0t: fired_tag expected %0d actual %0d",
                             $time, want.tag, o_fired_tag);
                    mismatch_count++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last expected %0b actual %0b", $time, want.last, o_last);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic reset_timer_model();
        half_period_m = HALF_PERIOD_RESET;
        count_m = '0;
        for (int i = 0; i <= NUM_ALARMS; i++) begin
            target_m[i]  = '0;
            enabled_m[i] = 1'b0;
            pending_m[i] = 1'b0;
        end
        for (int i = 0; i < NUM_ALARMS; i++) alarm_tag_m[i] = '0;
    endtask

    // advances the model by one request and queues the firings it causes
    task automatic predict_firings(input logic [1:0] mode, input logic [SEL_W-1:0] sel,
                                   input logic [DELAY_W-1:0] delay,
                                   input logic signed [TAG_W-1:0] tag);
        logic [CHAN_W-1:0]       chans [4];
        logic signed [TAG_W-1:0] tags  [4];
        t_fire_rec               rec;
        int                      n;
        n = 0;
        case (mode)
            MODE_SET: begin
                if (sel < NUM_ALARMS) begin
                    target_m[sel]    = count_m + delay;
                    alarm_tag_m[sel] = tag;
                    pending_m[sel]   = 1'b0;
                    enabled_m[sel]   = 1'b1;
                end
            end
            MODE_CANCEL: begin
                if (sel < NUM_ALARMS) begin
                    enabled_m[sel] = 1'b0;
                    pending_m[sel] = 1'b0;
                end
            end
            MODE_START: begin
                count_m = '0;
                for (int i = 0; i <= NUM_ALARMS; i++) begin
                    pending_m[i] = 1'b0;
                    enabled_m[i] = 1'b0;
                end
                target_m[PERIODIC_CHAN]  = half_period_m;
                enabled_m[PERIODIC_CHAN] = 1'b1;
            end
            MODE_TICK: begin
                count_m = count_m + 16'd1;
                // match latches even on a disabled channel
                for (int i = 0; i <= NUM_ALARMS; i++)
                    if (target_m[i] == count_m) pending_m[i] = 1'b1;
                if (pending_m[PERIODIC_CHAN] && enabled_m[PERIODIC_CHAN]) begin
                    pending_m[PERIODIC_CHAN] = 1'b0;
                    target_m[PERIODIC_CHAN]  = target_m[PERIODIC_CHAN] + half_period_m;
                    chans[n] = CHAN_W'(PERIODIC_CHAN);
                    tags[n]  = '0;
                    n++;
                end
                for (int i = 0; i < NUM_ALARMS; i++) begin
                    if (pending_m[i] && enabled_m[i]) begin
                        pending_m[i] = 1'b0;
                        enabled_m[i] = 1'b0;
                        chans[n] = CHAN_W'(i);
                        tags[n]  = alarm_tag_m[i];
                        n++;
                    end
                end
            end
        endcase
        for (int k = 0; k < n; k++) begin
            rec.chan = chans[k];
            rec.tag  = tags[k];
            rec.last = (k == n - 1);
            expected_firings.push_back(rec);
        end
    endtask

    // leaves valid high after the request so back-to-back requests go out without a gap
    task automatic send_request(input logic [1:0] mode, input logic [SEL_W-1:0] sel,
                                input logic [DELAY_W-1:0] delay,
                                input logic signed [TAG_W-1:0] tag);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= mode;
        i_alarm_select <= sel;
        i_delay_ticks  <= delay;
        i_tag          <= tag;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_firings(mode, sel, delay, tag);
    endtask

    task automatic send_tick();
        send_request(MODE_TICK, SEL_W'($urandom), DELAY_W'($urandom), $urandom);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (expected_firings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_half_period(input logic [HP_W-1:0] value);
        wait_drain();
        i_cfg_valid       <= 1'b1;
        i_cfg_half_period <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        half_period_m = value;
        i_cfg_valid <= 1'b0;
    endtask

    // periodic and all three alarms on one count, tags at their extremes
    task automatic test_all_channels();
        send_idle_pct = 0;
        stall_pct     = 0;
        write_half_period(16'd3);
        send_request(MODE_START, 2'd0, 16'd0, 32'sd0);
        send_request(MODE_SET, 2'd0, 16'd3, 32'sh7fffffff);
        send_request(MODE_SET, 2'd1, 16'd3, 32'sh80000000);
        send_request(MODE_SET, 2'd2, 16'd3, 32'shffffffff);
        repeat (6) send_tick();
    endtask

    // cancel, out-of-range select, and a match latched while disabled
    task automatic test_cancel_and_select();
        send_request(MODE_SET, 2'd1, 16'd2, 32'sh12345678);
        send_request(MODE_CANCEL, 2'd1, 16'hffff, 32'sd0);
        send_request(MODE_SET, 2'd3, 16'd1, 32'sh0badf00d);
        send_request(MODE_SET, 2'd0, 16'd1, 32'sh5a5a5a5a);
        send_request(MODE_CANCEL, 2'd3, 16'd0, 32'shffffffff);
        repeat (3) send_tick();
        send_request(MODE_SET, 2'd1, 16'd1, 32'sh00000001);
        send_tick();
    endtask

    // zero half period, zero delay and the largest delay stay quiet over a few ticks
    task automatic test_zero_and_max_delay();
        send_idle_pct = 0;
        stall_pct     = 0;
        write_half_period(16'd0);
        send_request(MODE_START, 2'd0, 16'd0, 32'sd0);
        send_request(MODE_SET, 2'd0, 16'd0, 32'sh00000001);
        send_request(MODE_SET, 2'd1, 16'hffff, 32'shdeadbeef);
        send_request(MODE_SET, 2'd2, 16'd2, 32'sh76543210);
        repeat (4) send_tick();
    endtask

    task automatic test_random_traffic(input int n_items, input int idle_pct, input int stall,
                                       input logic [HP_W-1:0] half_period);
        logic [1:0]              mode;
        logic [SEL_W-1:0]        sel;
        logic [DELAY_W-1:0]      delay;
        logic signed [TAG_W-1:0] tag;
        int                      pick;
        write_half_period(half_period);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)      mode = MODE_TICK;
            else if (pick < 80) mode = MODE_SET;
            else if (pick < 95) mode = MODE_CANCEL;
            else                mode = MODE_START;
            sel   = ($urandom_range(0, 9) == 0) ? SEL_W'(3) : SEL_W'($urandom_range(0, 2));
            delay = ($urandom_range(0, 9) == 0) ? DELAY_W'($urandom)
                                                : DELAY_W'($urandom_range(1, 8));
            tag   = $urandom;
            send_request(mode, sel, delay, tag);
            if ($urandom_range(0, 29) == 0) wait_drain();
        end
    endtask

    initial begin
        reset_timer_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_all_channels();
        test_cancel_and_select();
        test_zero_and_max_delay();
        test_random_traffic(40, 0, 0, 16'd1);
        test_random_traffic(40, 86, 0, 16'd4);
        test_random_traffic(40, 0, 86, 16'hffff);
        test_random_traffic(40, 11, 11, HP_W'($urandom_range(2, 7)));

        wait_drain();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
